### src/multi_entry_countdown_timer_table_macros.svh
// assertion macros for the countdown timer table
`ifndef MULTI_ENTRY_COUNTDOWN_TIMER_TABLE_MACROS_SVH
`define MULTI_ENTRY_COUNTDOWN_TIMER_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define MECT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MECT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mect_pkg.sv
// shared types and codes for the countdown timer table
package mect_pkg;

  localparam logic [1:0] FUNC_ARM    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  client_id;
    logic [15:0] delay_ms;
    logic [15:0] elapsed_ms;
  } req_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] expired_id;
    logic       accepted;
    logic       any_pending;
    logic       last_item;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_ARM,
    OP_CANCEL,
    OP_TICK,
    OP_NOP
  } op_t;

  // classified item; value is the delay for arm, the clamped elapsed time for tick
  typedef struct packed {
    op_t         op;
    logic        in_range;
    logic [3:0]  client_id;
    logic [15:0] value;
  } job_t;

  typedef struct packed {
    logic idle;
    logic any_pending;
  } back_stat_t;

endpackage

### src/multi_entry_countdown_timer_table.sv
// top level of the countdown timer table
// One-shot countdown timers, one per client index. Arm, cancel and unused
// operations each give one result from the back end. A tick walks every
// entry through the single read port of the remaining-time memory, one entry
// a cycle, then scans the expiry flags one entry a cycle up to the last
// expired client while the result side does not stall, emitting a result for
// each expired client in ascending order, or a single unfired result when
// none expires; the back end takes no new item until the tick is done. A
// two-entry queue lets the front keep taking items while a tick is in
// progress. Every result carries the pending state left after its item is
// fully applied.
`include "multi_entry_countdown_timer_table_macros.svh"

module multi_entry_countdown_timer_table #(
  parameter int NUM_CLIENTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mect_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mect_pkg::rsp_t rsp
);
  import mect_pkg::*;

  job_t       front_job;
  job_t       back_job;
  logic       push;
  logic       full;
  logic       pop;
  logic       nonempty;
  back_stat_t stat;

  mect_front #(.NUM_CLIENTS(NUM_CLIENTS)) u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .full      (full),
    .push      (push),
    .job       (front_job)
  );

  mect_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (front_job),
    .full     (full),
    .pop      (pop),
    .rdata    (back_job),
    .nonempty (nonempty)
  );

  mect_back #(.NUM_CLIENTS(NUM_CLIENTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (nonempty),
    .job       (back_job),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .stat      (stat)
  );

  // a shown result always matches the table's current pending state
  `MECT_ASSERT_IMP(a_pending_match, rsp_valid,
                   rsp.any_pending == stat.any_pending, "pending mismatch")
  // an unfired result is always the only result of its item
  `MECT_ASSERT_IMP(a_unfired_last, rsp_valid && !rsp.fired, rsp.last_item, "unfired not last")
  // more expiries to come means the back end is still busy
  `MECT_ASSERT_IMP(a_more_busy, rsp_valid && !rsp.last_item, !stat.idle, "idle mid-burst")
  // the table does not move while a result is stalled
  `MECT_ASSERT_NXT(a_stall_frozen, rsp_valid && !rsp_ready,
                   stat.any_pending == $past(stat.any_pending), "table moved in stall")

endmodule

### src/mect_front.sv
// front end: accepts items, decodes the operation and clamps the tick time
module mect_front #(
  parameter int NUM_CLIENTS = 16
) (
  input  logic          req_valid,
  output logic          req_ready,
  input  mect_pkg::req_t req,
  input  logic          full,
  output logic          push,
  output mect_pkg::job_t job
);
  import mect_pkg::*;

  assign req_ready = !full;
  assign push      = req_valid && !full;

  always_comb begin
    job.client_id = req.client_id;
    job.in_range  = (int'(req.client_id) < NUM_CLIENTS);
    unique case (req.func)
      FUNC_ARM: begin
        job.op    = OP_ARM;
        job.value = req.delay_ms;
      end
      FUNC_CANCEL: begin
        job.op    = OP_CANCEL;
        job.value = '0;
      end
      FUNC_TICK: begin
        job.op    = OP_TICK;
        // a zero elapsed time counts as one millisecond
        job.value = (req.elapsed_ms == '0) ? 16'd1 : req.elapsed_ms;
      end
      default: begin
        job.op    = OP_NOP;
        job.value = '0;
      end
    endcase
  end

endmodule

### src/mect_queue.sv
// two-entry queue of decoded jobs between front and back
module mect_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mect_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output mect_pkg::job_t rdata,
  output logic           nonempty
);
  import mect_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= wdata;
  end

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign rdata    = slot[rd_ptr];

endmodule

### src/mect_back.sv
// back end: entry table, tick walk over the remaining-time memory, result output
module mect_back #(
  parameter int NUM_CLIENTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  mect_pkg::job_t      job,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output mect_pkg::rsp_t      rsp,
  output mect_pkg::back_stat_t stat
);
  import mect_pkg::*;

  localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int CNT_W = $clog2(NUM_CLIENTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLIENTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                 state;
  logic [NUM_CLIENTS-1:0] valid;
  logic [NUM_CLIENTS-1:0] hit;
  logic [CNT_W-1:0]       pend_cnt;
  logic [CNT_W-1:0]       hit_cnt;
  logic [15:0]            elapsed;
  logic [IDX_W-1:0]       rd_ptr;
  logic                   issue_done;
  logic                   chk_vld;
  logic [IDX_W-1:0]       chk_idx;
  logic [IDX_W-1:0]       scan_ptr;
  logic [15:0]            rd_data;
  logic [15:0]            mem [NUM_CLIENTS];

  logic             out_free;
  logic             start;
  logic [IDX_W-1:0] job_idx;
  logic             arm_ok;
  logic             cancel_hit;
  logic             chk_live;
  logic             expire;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [15:0]      mem_wd;
  logic             emit_hit;
  logic             emit_none;
  logic             rsp_load;
  rsp_t             rsp_next;

  assign out_free   = !rsp_valid || rsp_ready;
  assign start      = (state == ST_IDLE) && job_valid && out_free;
  assign pop        = start;
  assign job_idx    = IDX_W'(job.client_id);
  assign arm_ok     = (job.op == OP_ARM) && job.in_range && !valid[job_idx];
  assign cancel_hit = (job.op == OP_CANCEL) && job.in_range && valid[job_idx];

  // rd_data belongs to chk_idx, read in the previous cycle
  assign chk_live = (state == ST_WALK) && chk_vld && valid[chk_idx];
  assign expire   = chk_live && (rd_data <= elapsed);

  assign mem_we = (start && arm_ok) || (chk_live && !expire);
  assign mem_wa = start ? job_idx : chk_idx;
  assign mem_wd = start ? job.value : (rd_data - elapsed);

  assign emit_hit  = (state == ST_EMIT) && (hit_cnt != '0) && hit[scan_ptr] && out_free;
  assign emit_none = (state == ST_EMIT) && (hit_cnt == '0) && out_free;
  assign rsp_load  = (start && (job.op != OP_TICK)) || emit_hit || emit_none;

  always_comb begin
    rsp_next.fired       = 1'b0;
    rsp_next.expired_id  = '0;
    rsp_next.accepted    = 1'b1;
    rsp_next.any_pending = (pend_cnt != '0);
    rsp_next.last_item   = 1'b1;
    if (emit_hit) begin
      rsp_next.fired      = 1'b1;
      rsp_next.expired_id = 4'(scan_ptr);
      rsp_next.last_item  = (hit_cnt == CNT_W'(1));
    end else if (state == ST_IDLE) begin
      rsp_next.accepted = (job.op != OP_ARM) || arm_ok;
      if (arm_ok) begin
        rsp_next.any_pending = 1'b1;
      end else if (cancel_hit) begin
        rsp_next.any_pending = (pend_cnt != CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      hit        <= '0;
      pend_cnt   <= '0;
      hit_cnt    <= '0;
      rd_ptr     <= '0;
      issue_done <= 1'b0;
      chk_vld    <= 1'b0;
      scan_ptr   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && !rsp_ready);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (job.op == OP_TICK) begin
              state      <= ST_WALK;
              rd_ptr     <= '0;
              issue_done <= 1'b0;
              chk_vld    <= 1'b0;
              hit_cnt    <= '0;
            end else begin
              if (arm_ok) begin
                valid[job_idx] <= 1'b1;
                pend_cnt       <= pend_cnt + CNT_W'(1);
              end else if (cancel_hit) begin
                valid[job_idx] <= 1'b0;
                pend_cnt       <= pend_cnt - CNT_W'(1);
              end
            end
          end
        end
        ST_WALK: begin
          if (!issue_done) begin
            chk_vld <= 1'b1;
            if (rd_ptr == LAST_IDX) issue_done <= 1'b1;
            else rd_ptr <= rd_ptr + IDX_W'(1);
          end else begin
            chk_vld <= 1'b0;
          end
          if (expire) begin
            valid[chk_idx] <= 1'b0;
            hit[chk_idx]   <= 1'b1;
            hit_cnt        <= hit_cnt + CNT_W'(1);
            pend_cnt       <= pend_cnt - CNT_W'(1);
          end
          // the last entry is checked after its issue, so chk_vld is already dropping
          if (chk_vld && (chk_idx == LAST_IDX)) begin
            state    <= ST_EMIT;
            scan_ptr <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_none) begin
            state <= ST_IDLE;
          end else if (hit_cnt != '0) begin
            if (hit[scan_ptr]) begin
              if (out_free) begin
                hit[scan_ptr] <= 1'b0;
                hit_cnt       <= hit_cnt - CNT_W'(1);
                if (hit_cnt == CNT_W'(1)) state <= ST_IDLE;
                else scan_ptr <= scan_ptr + IDX_W'(1);
              end
            end else begin
              scan_ptr <= scan_ptr + IDX_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) elapsed <= job.value;
    if ((state == ST_WALK) && !issue_done) chk_idx <= rd_ptr;
    if (rsp_load) rsp <= rsp_next;
  end

  // remaining-time memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_ptr];
  end

  assign stat.idle        = (state == ST_IDLE);
  assign stat.any_pending = (pend_cnt != '0);

endmodule
